/* hw/rtl/skp_pkg.sv */
// ----------------------------------------------------------------------------
// skp_pkg
// Shared types and constants of the short/long key-press scanner.
// ----------------------------------------------------------------------------
package skp_pkg;

    // number of scanned keys, fixed by the key_levels field width
    localparam int NUM_KEYS  = 3;
    localparam int CNT_W     = 8;
    localparam int CODE_W    = 3;
    localparam int CFG_IDX_W = 4;

    // register defaults after reset
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd3;
    localparam logic [CNT_W-1:0] LONG_RESET     = 8'd30;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = 4'd1;

    // button codes
    localparam logic [CODE_W-1:0] CODE_NOTHING = 3'd0;
    localparam logic [CODE_W-1:0] CODE_REPEAT  = 3'd7;

    // per-key status after this tick's scan
    typedef struct packed {
        logic short_pend;
        logic long_pend;
        logic event_hit;
    } skp_key_stat_t;

    // flag clears chosen by the code selector
    typedef struct packed {
        logic clr_short;
        logic clr_long;
    } skp_key_clr_t;

endpackage

/* hw/rtl/key_short_long_press_scanner_unit.sv */
// ----------------------------------------------------------------------------
// key_short_long_press_scanner_unit
// Debounced short/long press scanner for active-low keys, one code per tick.
// ----------------------------------------------------------------------------
// path: tick accept to code valid through input reg, then result reg
// throughput: 1 tick per cycle unless m_tready stalls the output; key state
//   updates in one pass as the tick moves from input into result register
// reset: all key state and last code cleared, debounce 3, long 30,
//   both channel registers empty; configuration always ready
module key_short_long_press_scanner_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // tick input; s_tdata: [2:0] key_levels, [7:3] zero
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    // code output; m_tdata: [2:0] button_code, [7:3] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,
    // configuration write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [skp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [skp_pkg::CNT_W-1:0]       cfg_data
);
    import skp_pkg::*;

    logic [CNT_W-1:0]    debounce_reg;
    logic [CNT_W-1:0]    long_reg;
    logic                in_valid_reg;
    logic [NUM_KEYS-1:0] in_levels_reg;
    logic                out_valid_reg;
    logic                out_free;
    logic                advance;
    logic [CODE_W-1:0]   last_code;
    skp_key_stat_t       stat [NUM_KEYS];
    skp_key_clr_t        clr  [NUM_KEYS];

    // handshake control
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            long_reg     <= LONG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data;
                REG_LONG:     long_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_levels_reg <= s_tdata[NUM_KEYS-1:0];
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // per-key trackers
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        skp_key_cell u_key (
            .clk            (clk),
            .rst_n          (rst_n),
            .advance        (advance),
            .key_pressed    (!in_levels_reg[k]),
            .debounce_ticks (debounce_reg),
            .long_ticks     (long_reg),
            .clr            (clr[k]),
            .stat           (stat[k])
        );
    end

    // code selection, holds the result register
    skp_code_sel u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .stat      (stat),
        .clr       (clr),
        .last_code (last_code)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - CODE_W){1'b0}}, last_code};

endmodule

/* hw/rtl/skp_key_cell.sv */
// ----------------------------------------------------------------------------
// skp_key_cell
// Debounce counter and short/long press tracking for one key.
// ----------------------------------------------------------------------------
module skp_key_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         key_pressed,
    input  logic [skp_pkg::CNT_W-1:0]    debounce_ticks,
    input  logic [skp_pkg::CNT_W-1:0]    long_ticks,
    input  skp_pkg::skp_key_clr_t        clr,
    output skp_pkg::skp_key_stat_t       stat
);
    import skp_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             released_reg, released_next;
    logic             phase_reg, phase_next;
    logic             short_reg, short_new;
    logic             long_reg, long_new;
    logic             event_hit;
    logic [CNT_W-1:0] count_inc;

    // saturating increment
    assign count_inc = (count_reg == {CNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;

    // per-tick press tracking
    always_comb
    begin
        count_next    = count_reg;
        released_next = released_reg;
        phase_next    = phase_reg;
        short_new     = short_reg;
        long_new      = long_reg;
        event_hit     = 1'b0;
        if (!key_pressed)
        begin
            released_next = 1'b1;
            count_next    = '0;
        end
        if (!phase_reg)
        begin
            if (key_pressed)
            begin
                count_next = count_inc;
                if ((count_inc > debounce_ticks) && released_reg)
                begin
                    released_next = 1'b0;
                    phase_next    = 1'b1;
                    short_new     = 1'b1;
                end
            end
        end
        else if (key_pressed)
        begin
            count_next = count_inc;
            if (count_inc >= long_ticks)
            begin
                long_new   = 1'b1;
                short_new  = 1'b0;
                count_next = '0;
                phase_next = 1'b0;
                event_hit  = 1'b1;
            end
        end
        else if (long_ticks != '0)
        begin
            // release before the long threshold: short press
            short_new  = 1'b1;
            phase_next = 1'b0;
            event_hit  = 1'b1;
        end
    end

    assign stat.short_pend = short_new;
    assign stat.long_pend  = long_new;
    assign stat.event_hit  = event_hit;

    // key state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            released_reg <= 1'b0;
            phase_reg    <= 1'b0;
            short_reg    <= 1'b0;
            long_reg     <= 1'b0;
        end
        else if (advance)
        begin
            count_reg    <= count_next;
            released_reg <= released_next;
            phase_reg    <= phase_next;
            short_reg    <= short_new & ~clr.clr_short;
            long_reg     <= long_new & ~clr.clr_long;
        end
    end

endmodule

/* hw/rtl/skp_code_sel.sv */
// ----------------------------------------------------------------------------
// skp_code_sel
// Priority selection of the button code with repeat detection.
// ----------------------------------------------------------------------------
module skp_code_sel (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  skp_pkg::skp_key_stat_t       stat [skp_pkg::NUM_KEYS],
    output skp_pkg::skp_key_clr_t        clr  [skp_pkg::NUM_KEYS],
    output logic [skp_pkg::CODE_W-1:0]   last_code
);
    import skp_pkg::*;

    logic [CODE_W-1:0] last_code_reg, last_code_next;
    logic [CODE_W-1:0] pick_code;
    logic              any_event;
    logic              found;

    // shorts first, then longs, lowest key first
    always_comb
    begin
        any_event = 1'b0;
        found     = 1'b0;
        pick_code = CODE_NOTHING;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            clr[k]    = '0;
            any_event = any_event | stat[k].event_hit;
        end
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (!found && stat[k].short_pend)
            begin
                found            = 1'b1;
                clr[k].clr_short = any_event;
                pick_code        = CODE_W'(k + 1);
            end
        end
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (!found && stat[k].long_pend)
            begin
                found           = 1'b1;
                clr[k].clr_long = any_event;
                pick_code       = CODE_W'(NUM_KEYS + k + 1);
            end
        end
    end

    // repeat detection
    always_comb
    begin
        last_code_next = last_code_reg;
        if (!any_event)
        begin
            last_code_next = CODE_NOTHING;
        end
        else if (found)
        begin
            if ((last_code_reg == pick_code) || (last_code_reg == CODE_REPEAT))
            begin
                last_code_next = CODE_REPEAT;
            end
            else
            begin
                last_code_next = pick_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_code_reg <= CODE_NOTHING;
        end
        else if (advance)
        begin
            last_code_reg <= last_code_next;
        end
    end

    assign last_code = last_code_reg;

endmodule
